// File: src/psts_pkg.sv
// Shared types and constants of the priority sum tree sampler.
package psts_pkg;

    localparam int CAP      = 1024;
    localparam int IDX_W    = 10;
    localparam int NODE_W   = 11;
    localparam int LIM_W    = 12;
    localparam int CNT_W    = 11;
    localparam int SUM_W    = 48;
    localparam int PRI_W    = 32;
    localparam int LVL_W    = 4;
    localparam int IN_W     = 96;
    localparam int OUT_W    = 128;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_UPDATE = 2'd1;
    localparam t_op OP_SAMPLE = 2'd2;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FALLBACK = 2'd1;
    localparam t_status ST_RANGE    = 2'd2;

    localparam logic [PRI_W-1:0] INIT_MAX_PRIORITY = 32'd65536;

endpackage

// File: src/psts_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module psts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: src/priority_sum_tree_sampler.sv
// Priority sum tree sampler: sum tree, min-heap and ring control for a 1024-entry replay store.
//
// One input beat carries an operation on s_axis (tuser) with its operands (tdata).
// Insert gives the next ring slot the running maximum priority, update sets the
// priority of a filled entry, sample walks the sum tree with a prefix value.
// Every input beat yields exactly one output beat on m_axis: the entry concerned,
// its priority, the root sum, the heap minimum and a status code in tuser.
// i_cfg_we with i_cfg_wdata loads the running maximum priority; write it idle.
// Operations run one at a time. Insert and update first do the leaf-to-root
// update, a read and then a write of the node at each tree level, then sift the
// entry through the heap; sample reads one node per tree level as it walks down.
// The single read port of the tree memory sets this pace.
// s_axis_tready is high only while no operation is in flight. The result sits in
// an output register; the next beat is accepted while it waits, and the block
// holds its last step until the receiver takes the previous result.
// Reset is synchronous: ring empty, maximum back to 1.0. The memories need no
// clearing pass: the fill count masks all entries that were never written.
module priority_sum_tree_sampler
    import psts_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [PRI_W-1:0] i_cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // entry_index[9:0], new_priority[41:10], prefix_value[89:42], zero fill
    input  logic [IN_W-1:0]  s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // result_index[9:0], result_priority[41:10], total_sum[89:42],
    // min_priority[121:90], zero fill
    output logic [OUT_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]       m_axis_tuser
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_TS_RD  = 5'd1;
    localparam logic [4:0] S_TS_WR  = 5'd2;
    localparam logic [4:0] S_HP_ST  = 5'd3;
    localparam logic [4:0] S_HP_POS = 5'd4;
    localparam logic [4:0] S_DN_CHK = 5'd5;
    localparam logic [4:0] S_DN_L1  = 5'd6;
    localparam logic [4:0] S_DN_L2  = 5'd7;
    localparam logic [4:0] S_DN_R1  = 5'd8;
    localparam logic [4:0] S_DN_R2  = 5'd9;
    localparam logic [4:0] S_DN_DEC = 5'd10;
    localparam logic [4:0] S_UP_CHK = 5'd11;
    localparam logic [4:0] S_UP_P1  = 5'd12;
    localparam logic [4:0] S_UP_P2  = 5'd13;
    localparam logic [4:0] S_FIX    = 5'd14;
    localparam logic [4:0] S_WK_CHK = 5'd15;
    localparam logic [4:0] S_WK_RD  = 5'd16;
    localparam logic [4:0] S_WK_END = 5'd17;
    localparam logic [4:0] S_WK_GET = 5'd18;
    localparam logic [4:0] S_FIN0   = 5'd19;
    localparam logic [4:0] S_FIN1   = 5'd20;
    localparam logic [4:0] S_FIN2   = 5'd21;

    logic [4:0]       r_state, n_state;
    logic [IDX_W-1:0] r_entry, n_entry;
    logic [PRI_W-1:0] r_prio, n_prio;
    logic [SUM_W-1:0] r_prefix, n_prefix;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_wp, n_wp;
    logic [PRI_W-1:0] r_max, n_max;
    logic [LIM_W-1:0] r_node, n_node;
    logic [SUM_W-1:0] r_delta, n_delta;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic             r_new, n_new;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic [IDX_W-1:0] r_el, n_el;
    logic [IDX_W-1:0] r_er, n_er;
    logic [PRI_W-1:0] r_lv, n_lv;
    logic [PRI_W-1:0] r_rv, n_rv;
    logic             r_rok, n_rok;
    logic             r_moved, n_moved;
    logic [SUM_W-1:0] r_tot, n_tot;
    logic [IDX_W-1:0] r_res_idx, n_res_idx;
    logic [PRI_W-1:0] r_res_pri, n_res_pri;
    t_status          r_status, n_status;
    logic             r_ovalid, n_ovalid;
    logic [OUT_W-1:0] r_odata, n_odata;
    t_status          r_ostat, n_ostat;

    // Memory ports.
    logic              t_we;
    logic [NODE_W-1:0] t_waddr, t_raddr;
    logic [SUM_W-1:0]  t_wdata, t_rdata;
    logic              h_we;
    logic [IDX_W-1:0]  h_waddr, h_wdata, h_raddr, h_rdata;
    logic              p_we;
    logic [IDX_W-1:0]  p_waddr, p_wdata, p_raddr, p_rdata;

    psts_ram #(.WIDTH(SUM_W), .DEPTH(2 * CAP)) u_tree (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    psts_ram #(.WIDTH(IDX_W), .DEPTH(CAP)) u_slots (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    psts_ram #(.WIDTH(IDX_W), .DEPTH(CAP)) u_posmap (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    // Input beat fields.
    t_op              w_op;
    logic [IDX_W-1:0] w_in_entry;
    logic [PRI_W-1:0] w_in_prio;
    logic [SUM_W-1:0] w_in_prefix;

    assign w_op        = s_axis_tuser;
    assign w_in_entry  = s_axis_tdata[9:0];
    assign w_in_prio   = s_axis_tdata[41:10];
    assign w_in_prefix = s_axis_tdata[89:42];

    // Heap and walk indexes.
    logic [LIM_W-1:0] w_dn_l, w_dn_r, w_fill12, w_limit, w_wl, w_wr;
    logic [IDX_W-1:0] w_parent;
    logic [20:0]      w_fl_sh;
    logic             w_wvalid;
    logic [SUM_W-1:0] w_wval;
    logic [IDX_W-1:0] w_lowmask;
    logic             w_tvalid;
    logic [SUM_W-1:0] w_told;
    logic             w_lsm, w_rsel, w_found;

    assign w_fill12  = {1'b0, r_fill};
    assign w_dn_l    = {1'b0, r_pos, 1'b1};
    assign w_dn_r    = w_dn_l + 12'd1;
    assign w_parent  = (r_pos - 10'd1) >> 1;
    assign w_limit   = 12'd1024 + w_fill12;
    assign w_wl      = {r_node[10:0], 1'b0};
    assign w_wr      = w_wl + 12'd1;
    // First leaf under node w_wl, which sits at depth r_lvl.
    assign w_fl_sh   = {w_wl[10:0], 10'b0} >> r_lvl;
    assign w_wvalid  = ({1'b0, w_fl_sh[9:0]} < r_fill);
    assign w_wval    = w_wvalid ? t_rdata : '0;

    // On a first insert into a slot, the leaf and every ancestor whose first
    // leaf is that slot have never been written and count as zero.
    assign w_lowmask = ~(10'h3FF << r_lvl);
    assign w_tvalid  = !(r_new && ((r_entry & w_lowmask) == '0));
    assign w_told    = w_tvalid ? t_rdata : '0;

    assign w_lsm   = r_lv < r_prio;
    assign w_rsel  = r_rok && (w_lsm ? (r_rv < r_lv) : (r_rv < r_prio));
    assign w_found = w_lsm || w_rsel;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ostat;

    always_comb begin
        n_state   = r_state;
        n_entry   = r_entry;
        n_prio    = r_prio;
        n_prefix  = r_prefix;
        n_fill    = r_fill;
        n_wp      = r_wp;
        n_max     = r_max;
        n_node    = r_node;
        n_delta   = r_delta;
        n_lvl     = r_lvl;
        n_new     = r_new;
        n_pos     = r_pos;
        n_el      = r_el;
        n_er      = r_er;
        n_lv      = r_lv;
        n_rv      = r_rv;
        n_rok     = r_rok;
        n_moved   = r_moved;
        n_tot     = r_tot;
        n_res_idx = r_res_idx;
        n_res_pri = r_res_pri;
        n_status  = r_status;
        n_ovalid  = r_ovalid;
        n_odata   = r_odata;
        n_ostat   = r_ostat;
        t_we      = 1'b0;
        t_waddr   = r_node[10:0];
        t_wdata   = '0;
        t_raddr   = r_node[10:0];
        h_we      = 1'b0;
        h_waddr   = r_pos;
        h_wdata   = r_el;
        h_raddr   = r_pos;
        p_we      = 1'b0;
        p_waddr   = r_el;
        p_wdata   = r_pos;
        p_raddr   = r_entry;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        if (i_cfg_we) begin
            n_max = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_status  = ST_OK;
                    n_res_idx = '0;
                    n_res_pri = '0;
                    n_moved   = 1'b0;
                    n_lvl     = '0;
                    n_new     = 1'b0;
                    case (w_op)
                        OP_INSERT: begin
                            n_entry   = r_wp;
                            n_prio    = r_max;
                            n_res_idx = r_wp;
                            n_res_pri = r_max;
                            n_node    = {2'b01, r_wp};
                            n_new     = (r_fill < CNT_W'(CAP));
                            if (r_fill < CNT_W'(CAP)) begin
                                n_fill = r_fill + 11'd1;
                            end
                            n_wp      = r_wp + 10'd1;
                            n_state   = S_TS_RD;
                        end
                        OP_UPDATE: begin
                            n_res_idx = w_in_entry;
                            if ({1'b0, w_in_entry} < r_fill) begin
                                n_entry   = w_in_entry;
                                n_prio    = w_in_prio;
                                n_res_pri = w_in_prio;
                                n_node    = {2'b01, w_in_entry};
                                if (w_in_prio > r_max) begin
                                    n_max = w_in_prio;
                                end
                                n_state = S_TS_RD;
                            end else begin
                                n_status = ST_RANGE;
                                n_state  = S_FIN0;
                            end
                        end
                        OP_SAMPLE: begin
                            if (r_fill == '0) begin
                                n_status = ST_RANGE;
                                n_state  = S_FIN0;
                            end else begin
                                n_prefix = w_in_prefix;
                                n_node   = 12'd1;
                                n_lvl    = 4'd1;
                                n_state  = S_WK_CHK;
                            end
                        end
                        default: begin
                            n_status = ST_RANGE;
                            n_state  = S_FIN0;
                        end
                    endcase
                end
            end

            // Leaf to root: the leaf takes the new value, ancestors add the delta.
            S_TS_RD: begin
                t_raddr = r_node[10:0];
                n_state = S_TS_WR;
            end
            S_TS_WR: begin
                t_we    = 1'b1;
                t_waddr = r_node[10:0];
                if (r_lvl == '0) begin
                    t_wdata = {16'd0, r_prio};
                    n_delta = {16'd0, r_prio} - w_told;
                end else begin
                    t_wdata = w_told + r_delta;
                end
                n_node = r_node >> 1;
                n_lvl  = r_lvl + 4'd1;
                if (r_node == 12'd1) begin
                    n_state = S_HP_ST;
                end else begin
                    n_state = S_TS_RD;
                end
            end

            S_HP_ST: begin
                if (r_new) begin
                    n_pos   = r_entry;
                    n_state = S_DN_CHK;
                end else begin
                    p_raddr = r_entry;
                    n_state = S_HP_POS;
                end
            end
            S_HP_POS: begin
                n_pos   = p_rdata;
                n_state = S_DN_CHK;
            end

            S_DN_CHK: begin
                if (w_dn_l >= w_fill12) begin
                    n_state = r_moved ? S_FIX : S_UP_CHK;
                end else begin
                    h_raddr = w_dn_l[9:0];
                    n_state = S_DN_L1;
                end
            end
            S_DN_L1: begin
                n_el    = h_rdata;
                t_raddr = {1'b1, h_rdata};
                n_state = S_DN_L2;
            end
            S_DN_L2: begin
                n_lv  = t_rdata[31:0];
                n_rok = 1'b0;
                if (w_dn_r < w_fill12) begin
                    h_raddr = w_dn_r[9:0];
                    n_state = S_DN_R1;
                end else begin
                    n_state = S_DN_DEC;
                end
            end
            S_DN_R1: begin
                n_er    = h_rdata;
                t_raddr = {1'b1, h_rdata};
                n_state = S_DN_R2;
            end
            S_DN_R2: begin
                n_rv    = t_rdata[31:0];
                n_rok   = 1'b1;
                n_state = S_DN_DEC;
            end
            S_DN_DEC: begin
                if (!w_found) begin
                    n_state = r_moved ? S_FIX : S_UP_CHK;
                end else begin
                    // The moving entry's own slot is written once, at the end.
                    h_we    = 1'b1;
                    h_waddr = r_pos;
                    h_wdata = w_rsel ? r_er : r_el;
                    p_we    = 1'b1;
                    p_waddr = w_rsel ? r_er : r_el;
                    p_wdata = r_pos;
                    n_pos   = w_rsel ? w_dn_r[9:0] : w_dn_l[9:0];
                    n_moved = 1'b1;
                    n_state = S_DN_CHK;
                end
            end

            S_UP_CHK: begin
                if (r_pos == '0) begin
                    n_state = S_FIX;
                end else begin
                    h_raddr = w_parent;
                    n_state = S_UP_P1;
                end
            end
            S_UP_P1: begin
                n_el    = h_rdata;
                t_raddr = {1'b1, h_rdata};
                n_state = S_UP_P2;
            end
            S_UP_P2: begin
                if (t_rdata[31:0] > r_prio) begin
                    h_we    = 1'b1;
                    h_waddr = r_pos;
                    h_wdata = r_el;
                    p_we    = 1'b1;
                    p_waddr = r_el;
                    p_wdata = r_pos;
                    n_pos   = w_parent;
                    n_state = S_UP_CHK;
                end else begin
                    n_state = S_FIX;
                end
            end

            S_FIX: begin
                h_we    = 1'b1;
                h_waddr = r_pos;
                h_wdata = r_entry;
                p_we    = 1'b1;
                p_waddr = r_entry;
                p_wdata = r_pos;
                n_state = S_FIN0;
            end

            S_WK_CHK: begin
                if (w_wl < w_limit) begin
                    t_raddr = w_wl[10:0];
                    n_state = S_WK_RD;
                end else begin
                    n_state = S_WK_END;
                end
            end
            S_WK_RD: begin
                n_lvl = r_lvl + 4'd1;
                if (r_prefix <= w_wval) begin
                    n_node  = w_wl;
                    n_state = S_WK_CHK;
                end else if (w_wr < w_limit) begin
                    n_prefix = r_prefix - w_wval;
                    n_node   = w_wr;
                    n_state  = S_WK_CHK;
                end else begin
                    n_node  = w_wl;
                    n_state = S_WK_END;
                end
            end
            S_WK_END: begin
                if (r_node >= w_limit || r_node < 12'd1024) begin
                    n_node   = w_limit - 12'd1;
                    n_status = ST_FALLBACK;
                end
                n_state = S_WK_GET;
            end
            S_WK_GET: begin
                t_raddr = r_node[10:0];
                n_state = S_FIN0;
                n_res_idx = r_node[9:0];
                // Result priority is picked up from the read in S_FIN0.
            end

            S_FIN0: begin
                if (r_op_is_sample_hit()) begin
                    n_res_pri = t_rdata[31:0];
                end
                t_raddr = 11'd1;
                h_raddr = '0;
                n_state = S_FIN1;
            end
            S_FIN1: begin
                n_tot   = (r_fill != '0) ? t_rdata : '0;
                n_el    = h_rdata;
                t_raddr = {1'b1, h_rdata};
                n_state = S_FIN2;
            end
            S_FIN2: begin
                t_raddr = {1'b1, r_el};
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {6'd0, ((r_fill != '0) ? t_rdata[31:0] : 32'd0),
                                r_tot, r_res_pri, r_res_idx};
                    n_ostat  = r_status;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // A sample that reached S_WK_GET leaves its leaf read pending for S_FIN0.
    logic r_wk_hit, n_wk_hit;

    function automatic logic r_op_is_sample_hit();
        return r_wk_hit;
    endfunction

    assign n_wk_hit = (r_state == S_WK_GET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_wp     <= '0;
            r_max    <= INIT_MAX_PRIORITY;
            r_ovalid <= 1'b0;
            r_wk_hit <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_wp     <= n_wp;
            r_max    <= n_max;
            r_ovalid <= n_ovalid;
            r_wk_hit <= n_wk_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry   <= n_entry;
        r_prio    <= n_prio;
        r_prefix  <= n_prefix;
        r_node    <= n_node;
        r_delta   <= n_delta;
        r_lvl     <= n_lvl;
        r_new     <= n_new;
        r_pos     <= n_pos;
        r_el      <= n_el;
        r_er      <= n_er;
        r_lv      <= n_lv;
        r_rv      <= n_rv;
        r_rok     <= n_rok;
        r_moved   <= n_moved;
        r_tot     <= n_tot;
        r_res_idx <= n_res_idx;
        r_res_pri <= n_res_pri;
        r_status  <= n_status;
        r_odata   <= n_odata;
        r_ostat   <= n_ostat;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAP))
        else $error("fill count beyond capacity");

    a_ring_pointer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill < CNT_W'(CAP)) |-> (r_wp == r_fill[9:0]))
        else $error("write pointer out of step with fill count before wrap");

    a_heap_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) |-> ({1'b0, r_pos} < r_fill))
        else $error("heap position outside filled heap");

    a_out_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN2 && !r_ovalid) |=> (m_axis_tvalid && r_state == S_IDLE))
        else $error("finished result not presented");
`endif

endmodule

// File: test/testbench.sv
// Self-checking testbench for the priority sum tree sampler.
`timescale 1ns / 100ps

module testbench;
    import psts_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [PRI_W-1:0] priority_val;
        logic [SUM_W-1:0] total;
        logic [PRI_W-1:0] minimum;
        t_status          status;
    } t_replay_result;

    // Predicts every result from its own copy of the tree, the heap and the ring
    // control, and compares the results of the block against it in order.
    class replay_store_scoreboard;
        logic [SUM_W-1:0] tree[2*CAP];
        int unsigned      heap_slot[CAP];
        int unsigned      heap_pos[CAP];
        bit               placed[CAP];
        int unsigned      wptr;
        int unsigned      fill;
        logic [PRI_W-1:0] max_prio;
        t_replay_result   pending[$];
        int               errors;
        int               n_insert, n_update, n_sample, n_range, n_fallback, n_wrap;

        function void clear();
            for (int i = 0; i < 2*CAP; i++) tree[i] = '0;
            for (int i = 0; i < CAP; i++) begin
                heap_slot[i] = i;
                heap_pos[i]  = 0;
                placed[i]    = 0;
            end
            wptr = 0;
            fill = 0;
            max_prio = INIT_MAX_PRIORITY;
            errors = 0;
        endfunction

        function void load_max(logic [PRI_W-1:0] v);
            max_prio = v;
        endfunction

        function logic [SUM_W-1:0] leaf(int unsigned e);
            return tree[CAP + e];
        endfunction

        function void set_leaf(int unsigned e, logic [SUM_W-1:0] p);
            int unsigned      node;
            logic [SUM_W-1:0] delta;
            node  = CAP + e;
            delta = p - tree[node];
            while (node > 0) begin
                tree[node] = tree[node] + delta;
                node = node / 2;
            end
        endfunction

        function void swap_slots(int unsigned a, int unsigned b);
            int unsigned ea, eb;
            ea = heap_slot[a];
            eb = heap_slot[b];
            heap_slot[a] = eb;
            heap_slot[b] = ea;
            heap_pos[eb] = a;
            heap_pos[ea] = b;
        endfunction

        // Sift down first; only an entry that did not move down may rise.
        function void sift(int unsigned e);
            int unsigned      pos, l, r, child;
            bit               found, moved;
            logic [SUM_W-1:0] me;
            moved = 0;
            me = leaf(e);
            if (!placed[e]) begin
                placed[e]   = 1;
                heap_pos[e] = e;
            end
            pos = heap_pos[e];
            forever begin
                l = 2*pos + 1;
                r = l + 1;
                child = pos;
                found = 0;
                if (l >= fill) break;
                if (leaf(heap_slot[l]) < me) begin
                    child = l;
                    found = 1;
                end
                if (r < fill) begin
                    if (found ? (leaf(heap_slot[r]) < leaf(heap_slot[l]))
                              : (leaf(heap_slot[r]) < me)) begin
                        child = r;
                        found = 1;
                    end
                end
                if (!found) break;
                swap_slots(pos, child);
                pos = child;
                moved = 1;
            end
            if (!moved) begin
                while (pos > 0) begin
                    if (leaf(heap_slot[(pos-1)/2]) > me) begin
                        swap_slots((pos-1)/2, pos);
                        pos = (pos-1)/2;
                    end else begin
                        break;
                    end
                end
            end
        endfunction

        function void note_beat(t_op op, logic [IDX_W-1:0] idx, logic [PRI_W-1:0] prio,
                                logic [SUM_W-1:0] prefix);
            t_replay_result r;
            int unsigned    slot, limit, node;
            r = '0;
            r.status = ST_OK;
            case (op)
                OP_INSERT: begin
                    n_insert++;
                    slot = wptr;
                    if (fill < CAP) fill++;
                    else n_wrap++;
                    set_leaf(slot, max_prio);
                    sift(slot);
                    wptr = (slot + 1) % CAP;
                    r.index = slot;
                    r.priority_val = max_prio;
                end
                OP_UPDATE: begin
                    n_update++;
                    r.index = idx;
                    if (idx >= fill) begin
                        r.status = ST_RANGE;
                        n_range++;
                    end else begin
                        set_leaf(idx, prio);
                        sift(idx);
                        if (prio > max_prio) max_prio = prio;
                        r.priority_val = prio;
                    end
                end
                OP_SAMPLE: begin
                    n_sample++;
                    if (fill == 0) begin
                        r.status = ST_RANGE;
                        n_range++;
                    end else begin
                        limit = CAP + fill;
                        node  = 1;
                        while (node*2 < limit) begin
                            if (prefix <= tree[node*2]) begin
                                node = node*2;
                            end else if (node*2 + 1 < limit) begin
                                prefix = prefix - tree[node*2];
                                node = node*2 + 1;
                            end else begin
                                node = node*2;
                                break;
                            end
                        end
                        if (node >= limit || node < CAP) begin
                            node = limit - 1;
                            r.status = ST_FALLBACK;
                            n_fallback++;
                        end
                        r.index = node - CAP;
                        r.priority_val = tree[node];
                    end
                end
                default: begin
                    r.status = ST_RANGE;
                    n_range++;
                end
            endcase
            r.total   = tree[1];
            r.minimum = (fill > 0) ? leaf(heap_slot[0]) : '0;
            pending.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        endtask

        task check_beat(logic [OUT_W-1:0] data, logic [1:0] user);
            t_replay_result e;
            if (pending.size() == 0) begin
                report("unexpected result beat", data[IDX_W-1:0], 0);
                return;
            end
            e = pending.pop_front();
            if (data[9:0] !== e.index)          report("result_index", data[9:0], e.index);
            if (data[41:10] !== e.priority_val) report("result_priority", data[41:10],
                                                       e.priority_val);
            if (data[89:42] !== e.total)        report("total_sum", data[89:42], e.total);
            if (data[121:90] !== e.minimum)     report("min_priority", data[121:90], e.minimum);
            if (user !== e.status)              report("status", user, e.status);
        endtask
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [PRI_W-1:0] i_cfg_wdata;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;
    logic [1:0]       s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;
    logic [1:0]       m_axis_tuser;

    replay_store_scoreboard sb;
    int idle_mode;  // 0 none, 1 sender, 2 receiver, 3 both lightly

    priority_sum_tree_sampler uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic bit idle_roll(bit sender);
        case (idle_mode)
            1: return sender && ($urandom_range(0, 99) < 78);
            2: return !sender && ($urandom_range(0, 99) < 78);
            3: return $urandom_range(0, 99) < 8;
            default: return 0;
        endcase
    endfunction

    // Result side: check every accepted beat, then pick the ready level for the next edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= !idle_roll(0);
        end
    end

    task send_op(t_op op, logic [IDX_W-1:0] idx, logic [PRI_W-1:0] prio,
                 logic [SUM_W-1:0] prefix);
        int gap;
        gap = 0;
        while (idle_roll(1)) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'd0, prefix, prio, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_beat(op, idx, prio, prefix);
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task write_max(logic [PRI_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.load_max(v);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [PRI_W-1:0] pick_priority();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return $urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [SUM_W-1:0] pick_prefix();
        logic [63:0] total, raw;
        total = sb.tree[1];
        raw   = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: return raw[SUM_W-1:0];
            1: return '0;
            2: return total[SUM_W-1:0];
            default: return raw % (total + 1);
        endcase
    endfunction

    task random_phase(int items, int insert_pct);
        int  roll;
        t_op op;
        logic [IDX_W-1:0] idx;
        for (int n = 0; n < items; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < insert_pct) op = OP_INSERT;
            else if (roll < insert_pct + (100 - insert_pct) / 2) op = OP_UPDATE;
            else if (roll < 98) op = OP_SAMPLE;
            else op = t_op'(2'd3);
            if (sb.fill > 0 && $urandom_range(0, 9) < 8) idx = $urandom_range(0, sb.fill - 1);
            else idx = $urandom;
            send_op(op, idx, pick_priority(), pick_prefix());
            // Once in the run the sender holds off until the store has answered everything.
            if (n == 100 && idle_mode == 0) drain();
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        idle_mode     = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_INSERT;
        m_axis_tready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty store, out of range update and the unused code, then a few entries.
        send_op(OP_SAMPLE, 10'd0, '0, '0);
        send_op(OP_UPDATE, 10'd1023, '1, '1);
        send_op(t_op'(2'd3), 10'd5, 32'h1234, 48'h55);
        send_op(OP_INSERT, '0, '0, '0);
        send_op(OP_INSERT, '1, '1, '1);
        send_op(OP_INSERT, '0, '0, '0);
        send_op(OP_UPDATE, 10'd0, '1, '0);
        send_op(OP_INSERT, '0, '0, '0);
        send_op(OP_UPDATE, 10'd1, '0, '0);
        send_op(OP_UPDATE, 10'd2, 32'd1, '0);
        send_op(OP_SAMPLE, '0, '0, '0);
        send_op(OP_SAMPLE, '0, '0, '1);
        send_op(OP_SAMPLE, '0, '0, sb.tree[1]);
        send_op(OP_SAMPLE, '0, '0, 48'd1);
        send_op(OP_UPDATE, 10'd1023, '0, '0);
        write_max(32'h0001_8000);
        send_op(OP_INSERT, '0, '0, '0);
        send_op(OP_UPDATE, 10'd4, 32'h0000_8000, '0);
        send_op(OP_SAMPLE, '0, '0, 48'h1_0000);

        // Heavy inserts up front so the ring fills and wraps later on.
        write_max('1);
        random_phase(750, 90);
        write_max('0);
        idle_mode = 1;
        random_phase(170, 75);
        write_max($urandom);
        idle_mode = 2;
        random_phase(170, 75);
        write_max(INIT_MAX_PRIORITY);
        idle_mode = 3;
        random_phase(170, 75);

        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d inserts (%0d past a full ring), %0d updates, %0d samples.",
                 sb.n_insert, sb.n_wrap, sb.n_update, sb.n_sample);
        $display("Seen %0d range rejections and %0d search fallbacks; mismatches: %0d.",
                 sb.n_range, sb.n_fallback, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("Timeout with %0d results outstanding.", sb.pending.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
src/psts_pkg.sv
src/psts_ram.sv
src/priority_sum_tree_sampler.sv
test/testbench.sv
